/* hw/rtl/cna_pkg.sv */
// shared types, constants and step functions of the complex arithmetic unit
package cna_pkg;

  localparam int FRAC_BITS = 16;
  // quotient bits kept by the divider; also the root bits of the square root
  localparam int QW = 33;
  localparam int ITER_STEPS = QW;
  localparam int OVF_SH = QW - FRAC_BITS;
  localparam int OW = 64 + OVF_SH;
  localparam logic [64:0] HALF = (65'd1 << FRAC_BITS) >> 1;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_NEG = 3'd4;
  localparam logic [2:0] OP_MAG = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic signed [32:0] S33_MAX = 33'sd2147483647;
  localparam logic signed [32:0] S33_MIN = -33'sd2147483648;
  localparam logic [31:0] POS_LIM = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIM = 32'h8000_0000;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic [1:0]         status;
  } res_t;

  // finished results of the short operations, carried along the pipe
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] fix_re;
    logic [31:0] fix_im;
    logic        fix_sat;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic signed [63:0] p_rr;
    logic signed [63:0] p_ii;
    logic signed [63:0] p_ri;
    logic signed [63:0] p_ir;
    logic [63:0]        q_r;
    logic [63:0]        q_i;
  } prod_t;

  typedef struct packed {
    side_t              side;
    logic signed [64:0] sr;
    logic signed [64:0] si;
    logic [63:0]        d;
  } sum_t;

  typedef struct packed {
    side_t       side;
    logic        neg_r;
    logic        neg_i;
    logic [63:0] mag_r;
    logic [63:0] mag_i;
    logic [63:0] d;
  } split_t;

  typedef struct packed {
    side_t         side;
    logic          neg_r;
    logic          neg_i;
    logic          dz;
    logic          ovf_r;
    logic          ovf_i;
    logic [63:0]   d;
    logic [63:0]   rem_re;
    logic [63:0]   rem_im;
    logic [QW-1:0] lo_re;
    logic [QW-1:0] lo_im;
    logic [QW-1:0] q_re;
    logic [QW-1:0] q_im;
    logic [65:0]   sq_src;
    logic [34:0]   sq_rem;
    logic [QW-1:0] sq_root;
  } iter_t;

  // sign and magnitude to saturated 32-bit value, flag on top
  function automatic logic [32:0] sat_mag(input logic neg, input logic [64:0] mag);
    logic [32:0] r;
    if (!neg && mag > 65'(POS_LIM)) begin
      r = {1'b1, POS_LIM};
    end else if (neg && mag > 65'(NEG_LIM)) begin
      r = {1'b1, NEG_LIM};
    end else if (neg) begin
      r = {1'b0, 32'(32'd0 - mag[31:0])};
    end else begin
      r = {1'b0, mag[31:0]};
    end
    return r;
  endfunction

  function automatic logic [32:0] sat_s33(input logic signed [32:0] x);
    logic [32:0] r;
    if (x > S33_MAX) begin
      r = {1'b1, POS_LIM};
    end else if (x < S33_MIN) begin
      r = {1'b1, NEG_LIM};
    end else begin
      r = {1'b0, x[31:0]};
    end
    return r;
  endfunction

  // one restoring step for both quotient lanes and the root lane
  function automatic iter_t iter_step(input iter_t s);
    iter_t       n;
    logic [64:0] tr;
    logic [64:0] ti;
    logic        ger;
    logic        gei;
    logic [36:0] ts;
    logic [36:0] trial;
    logic        ges;
    n = s;
    tr = {s.rem_re, s.lo_re[QW-1]};
    ti = {s.rem_im, s.lo_im[QW-1]};
    ger = tr >= {1'b0, s.d};
    gei = ti >= {1'b0, s.d};
    n.rem_re = ger ? 64'(tr - {1'b0, s.d}) : tr[63:0];
    n.rem_im = gei ? 64'(ti - {1'b0, s.d}) : ti[63:0];
    n.q_re = {s.q_re[QW-2:0], ger};
    n.q_im = {s.q_im[QW-2:0], gei};
    n.lo_re = s.lo_re << 1;
    n.lo_im = s.lo_im << 1;
    ts = {s.sq_rem, s.sq_src[65:64]};
    trial = {2'b00, s.sq_root, 2'b01};
    ges = ts >= trial;
    n.sq_rem = ges ? 35'(ts - trial) : ts[34:0];
    n.sq_root = {s.sq_root[QW-2:0], ges};
    n.sq_src = s.sq_src << 2;
    return n;
  endfunction

endpackage

/* hw/rtl/cna_iter.sv */
// stage row of the pipelined divider and square root
module cna_iter (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_v,
  input  cna_pkg::iter_t in_data,
  output logic           out_v,
  output cna_pkg::iter_t out_data
);
  import cna_pkg::*;

  iter_t                 stg [ITER_STEPS];
  logic [ITER_STEPS-1:0] v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[ITER_STEPS-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= iter_step(in_data);
      for (int k = 1; k < ITER_STEPS; k++) begin
        stg[k] <= iter_step(stg[k-1]);
      end
    end
  end

  assign out_v    = v[ITER_STEPS-1];
  assign out_data = stg[ITER_STEPS-1];

endmodule

/* hw/rtl/complex_number_alu.sv */
// top level of the pipelined complex arithmetic unit
// Complex arithmetic on signed Q16.16 operands: add, subtract, multiply,
// divide, negate a and magnitude of a. The unit is fully pipelined: it takes
// one item per cycle while cmd_ready is high and returns the results in
// order, whatever the operation. The divider and square root resolve one
// quotient bit and one root bit per stage over 33 stages, behind four
// stages of operand capture, multiplication, sums and sign split, one setup
// stage and the output register. A skid register after the output lets the
// unit take one more item while a result waits; cmd_ready drops only while
// the skid register is full. Divide by zero gives zero with status 1; a
// saturated part gives status 2. Codes 6 and 7 give zero.
module complex_number_alu (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  cna_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output cna_pkg::res_t res
);
  import cna_pkg::*;

  // whole pipe advances together unless the skid register is holding a result
  logic   en;
  logic   skid_v;
  res_t   skid;

  logic   v1, v2, v3, v4, v5;
  cmd_t   s1;
  prod_t  s2;
  sum_t   s3;
  split_t s4;
  iter_t  s5;

  prod_t  s2_next;
  sum_t   s3_next;
  split_t s4_next;
  iter_t  s5_next;

  logic   it_v;
  iter_t  it;
  res_t   fin;

  assign en        = !skid_v;
  assign cmd_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= cmd_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= cmd;
      s2 <= s2_next;
      s3 <= s3_next;
      s4 <= s4_next;
      s5 <= s5_next;
    end
  end

  // stage 2: the products, and the finished short operations
  always_comb begin
    logic signed [31:0] yr;
    logic signed [31:0] yi;
    logic [32:0]        rr;
    logic [32:0]        ri;
    // magnitude squares a instead of multiplying by b
    yr = (s1.operation == OP_MAG) ? s1.a_re : s1.b_re;
    yi = (s1.operation == OP_MAG) ? s1.a_im : s1.b_im;
    s2_next.p_rr = 64'(s1.a_re) * 64'(yr);
    s2_next.p_ii = 64'(s1.a_im) * 64'(yi);
    s2_next.p_ri = 64'(s1.a_re) * 64'(s1.b_im);
    s2_next.p_ir = 64'(s1.a_im) * 64'(s1.b_re);
    s2_next.q_r  = 64'(s1.b_re) * 64'(s1.b_re);
    s2_next.q_i  = 64'(s1.b_im) * 64'(s1.b_im);
    case (s1.operation)
      OP_ADD: begin
        rr = sat_s33(33'(s1.a_re) + 33'(s1.b_re));
        ri = sat_s33(33'(s1.a_im) + 33'(s1.b_im));
      end
      OP_SUB: begin
        rr = sat_s33(33'(s1.a_re) - 33'(s1.b_re));
        ri = sat_s33(33'(s1.a_im) - 33'(s1.b_im));
      end
      OP_NEG: begin
        rr = sat_s33(33'sd0 - 33'(s1.a_re));
        ri = sat_s33(33'sd0 - 33'(s1.a_im));
      end
      default: begin
        rr = '0;
        ri = '0;
      end
    endcase
    s2_next.side.op      = s1.operation;
    s2_next.side.fix_re  = rr[31:0];
    s2_next.side.fix_im  = ri[31:0];
    s2_next.side.fix_sat = rr[32] | ri[32];
  end

  // stage 3: exact cross sums and the divisor norm
  always_comb begin
    s3_next.side = s2.side;
    s3_next.d    = s2.q_r + s2.q_i;
    case (s2.side.op)
      OP_MUL: begin
        s3_next.sr = 65'(s2.p_rr) - 65'(s2.p_ii);
        s3_next.si = 65'(s2.p_ri) + 65'(s2.p_ir);
      end
      OP_DIV: begin
        s3_next.sr = 65'(s2.p_rr) + 65'(s2.p_ii);
        s3_next.si = 65'(s2.p_ir) - 65'(s2.p_ri);
      end
      default: begin
        // magnitude: sum of squares, never negative
        s3_next.sr = 65'(s2.p_rr) + 65'(s2.p_ii);
        s3_next.si = '0;
      end
    endcase
  end

  // stage 4: sign and magnitude
  always_comb begin
    s4_next.side  = s3.side;
    s4_next.d     = s3.d;
    s4_next.neg_r = s3.sr[64];
    s4_next.neg_i = s3.si[64];
    s4_next.mag_r = s3.sr[64] ? 64'(-s3.sr) : s3.sr[63:0];
    s4_next.mag_i = s3.si[64] ? 64'(-s3.si) : s3.si[63:0];
  end

  // stage 5: product rounding, divider and root setup
  always_comb begin
    logic [64:0] rnd_r;
    logic [64:0] rnd_i;
    logic [32:0] mr;
    logic [32:0] mi;
    rnd_r = (65'(s4.mag_r) + HALF) >> FRAC_BITS;
    rnd_i = (65'(s4.mag_i) + HALF) >> FRAC_BITS;
    mr = sat_mag(s4.neg_r, rnd_r);
    mi = sat_mag(s4.neg_i, rnd_i);
    s5_next.side = s4.side;
    if (s4.side.op == OP_MUL) begin
      s5_next.side.fix_re  = mr[31:0];
      s5_next.side.fix_im  = mi[31:0];
      s5_next.side.fix_sat = mr[32] | mi[32];
    end
    s5_next.neg_r = s4.neg_r;
    s5_next.neg_i = s4.neg_i;
    s5_next.d     = s4.d;
    s5_next.dz    = (s4.d == 64'd0);
    // quotient would not fit the kept bits
    s5_next.ovf_r  = OW'(s4.mag_r) >= (OW'(s4.d) << OVF_SH);
    s5_next.ovf_i  = OW'(s4.mag_i) >= (OW'(s4.d) << OVF_SH);
    s5_next.rem_re = s4.mag_r >> OVF_SH;
    s5_next.rem_im = s4.mag_i >> OVF_SH;
    s5_next.lo_re  = QW'(s4.mag_r << FRAC_BITS);
    s5_next.lo_im  = QW'(s4.mag_i << FRAC_BITS);
    s5_next.q_re   = '0;
    s5_next.q_im   = '0;
    // root of 4x, halved at the end, gives floor of the root of x
    s5_next.sq_src  = {s4.mag_r, 2'b00};
    s5_next.sq_rem  = '0;
    s5_next.sq_root = '0;
  end

  cna_iter u_iter (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (v5),
    .in_data  (s5),
    .out_v    (it_v),
    .out_data (it)
  );

  // result selection
  always_comb begin
    logic [32:0] fr;
    logic [32:0] fi;
    logic        sat;
    fin = '0;
    fr  = '0;
    fi  = '0;
    sat = 1'b0;
    case (it.side.op)
      OP_ADD, OP_SUB, OP_NEG, OP_MUL: begin
        fin.res_re = it.side.fix_re;
        fin.res_im = it.side.fix_im;
        sat        = it.side.fix_sat;
      end
      OP_DIV: begin
        if (!it.dz) begin
          fr = sat_mag(it.neg_r, it.ovf_r ? {65{1'b1}} : 65'(it.q_re));
          fi = sat_mag(it.neg_i, it.ovf_i ? {65{1'b1}} : 65'(it.q_im));
          fin.res_re = fr[31:0];
          fin.res_im = fi[31:0];
          sat        = fr[32] | fi[32];
        end
      end
      OP_MAG: begin
        fr = sat_mag(1'b0, 65'(it.sq_root >> 1));
        fin.res_re = fr[31:0];
        sat        = fr[32];
      end
      default: begin
        sat = 1'b0;
      end
    endcase
    if (it.side.op == OP_DIV && it.dz) begin
      fin.status = ST_DIV0;
    end else if (sat) begin
      fin.status = ST_SAT;
    end else begin
      fin.status = ST_OK;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!res_valid || res_ready) begin
      if (skid_v) begin
        res_valid <= 1'b1;
        skid_v    <= 1'b0;
      end else begin
        res_valid <= it_v;
      end
    end else if (en && it_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || res_ready) begin
      res <= skid_v ? skid : fin;
    end else if (en && it_v) begin
      skid <= fin;
    end
  end

endmodule

/* hw/rtl/cna_checker.sv */
// port-level checks of the complex arithmetic unit, bound to the top level
module cna_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_ready,
  input cna_pkg::cmd_t cmd,
  input logic          res_valid,
  input logic          res_ready,
  input cna_pkg::res_t res
);
  import cna_pkg::*;

  a_no_valid_after_rst: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.status != 2'd3)
    else $error("unknown status code");

  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_DIV0) |-> (res.res_re == 0 && res.res_im == 0))
    else $error("divide by zero item with nonzero result");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_SAT) |->
      (res.res_re == POS_LIM || res.res_re == NEG_LIM ||
       res.res_im == POS_LIM || res.res_im == NEG_LIM))
    else $error("saturated item with no part at a limit");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("stalled result changed");

endmodule

bind complex_number_alu cna_checker u_cna_checker (.*);
